/* src/hbw_pkg.sv */
// Shared types and constants for the heartbeat watchdog table.
`timescale 1ns / 1ps

package hbw_pkg;

   localparam int ID_W      = 22;
   localparam int PER_W     = 16;
   localparam int TIME_W    = 32;
   localparam int FACTOR_W  = 4;
   localparam int LIMIT_W   = 8;
   localparam int TOTAL_W   = 8;
   localparam int STATUS_W  = 3;
   localparam int COUNT_W   = 5;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_FACTOR = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REBOOT_LIMIT   = 1'd1;

   localparam logic [FACTOR_W-1:0] FACTOR_RESET = 4'd2;
   localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 8'd3;
   localparam logic [TOTAL_W-1:0]  TOTAL_MAX    = 8'hFF;

   typedef enum logic [STATUS_W-1:0] {
      ST_REFRESHED  = 3'd0,
      ST_REGISTERED = 3'd1,
      ST_DROPPED    = 3'd2,
      ST_TICK_OK    = 3'd3,
      ST_TIMEOUT    = 3'd4
   } status_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [PER_W-1:0]  period;
      logic [TIME_W-1:0] last_seen;
   } entry_type;

   typedef struct packed {
      logic [FACTOR_W-1:0] timeout_factor;
      logic [LIMIT_W-1:0]  reboot_limit;
   } cfg_type;

   typedef struct packed {
      logic                valid;
      status_type          status;
      logic [ID_W-1:0]     expired_id;
      logic [TOTAL_W-1:0]  timeout_total;
      logic                reboot_request;
      logic [COUNT_W-1:0]  client_count;
   } result_type;

endpackage

/* src/hbw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module hbw_ram #(
   parameter int WIDTH = 70,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* src/hbw_ctrl.sv */
// Scan sequencer: walks the client table in RAM for heartbeats and ticks.
`timescale 1ns / 1ps

module hbw_ctrl #(
   parameter int MAX_CLIENTS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic                       req_action,
   input  logic [hbw_pkg::ID_W-1:0]   req_client_id,
   input  logic [hbw_pkg::PER_W-1:0]  req_period,
   input  hbw_pkg::cfg_type           cfg,
   output logic                       busy,
   output hbw_pkg::result_type        result
);

   localparam int IDX_W = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
   localparam int CNT_W = $clog2(MAX_CLIENTS + 1);
   localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_CLIENTS);
   localparam int PROD_W = hbw_pkg::FACTOR_W + hbw_pkg::PER_W;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_SCAN = 2'b10
   } state_type;

   state_type                     state_ff, state_in;
   logic                          action_ff, action_in;
   logic [hbw_pkg::ID_W-1:0]      id_ff, id_in;
   logic [hbw_pkg::PER_W-1:0]     period_ff, period_in;
   logic [hbw_pkg::TIME_W-1:0]    time_ff, time_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [hbw_pkg::TOTAL_W-1:0]   total_ff, total_in;
   logic [CNT_W-1:0]              issue_ff, issue_in;
   logic                          rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]              rd_idx_ff, rd_idx_in;

   hbw_pkg::entry_type            rd_entry;
   hbw_pkg::entry_type            wr_entry;
   logic                          wr_en;
   logic [IDX_W-1:0]              wr_addr;
   logic                          rd_en;
   logic [hbw_pkg::TIME_W-1:0]    age;
   logic [PROD_W-1:0]             limit;
   logic                          expired;
   logic                          match;
   logic                          scan_end;
   logic                          done;
   logic [hbw_pkg::TOTAL_W-1:0]   total_inc;
   logic [CNT_W+4:0]              count_ext;

   hbw_ram #(
      .WIDTH ($bits(hbw_pkg::entry_type)),
      .DEPTH (MAX_CLIENTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[IDX_W-1:0]),
      .rd_data (rd_entry)
   );

   assign age      = time_ff - rd_entry.last_seen;
   assign limit    = PROD_W'(cfg.timeout_factor) * PROD_W'(rd_entry.period);
   assign expired  = age > hbw_pkg::TIME_W'(limit);
   assign match    = rd_valid_ff && (action_ff ? expired : (rd_entry.id == id_ff));
   assign scan_end = (issue_ff == count_ff) && !rd_valid_ff;
   assign done     = (state_ff == S_SCAN) && (match || scan_end);
   assign rd_en    = (state_ff == S_SCAN) && !match && (issue_ff != count_ff);
   assign busy     = (state_ff != S_IDLE);
   assign total_inc = (total_ff == hbw_pkg::TOTAL_MAX) ? total_ff
                                                       : total_ff + hbw_pkg::TOTAL_W'(1);
   assign wr_entry = '{id: id_ff, period: period_ff, last_seen: time_ff};

   always_comb begin
      state_in    = state_ff;
      action_in   = action_ff;
      id_in       = id_ff;
      period_in   = period_ff;
      time_in     = time_ff;
      count_in    = count_ff;
      total_in    = total_ff;
      issue_in    = issue_ff;
      rd_valid_in = 1'b0;
      rd_idx_in   = rd_idx_ff;
      wr_en       = 1'b0;
      wr_addr     = rd_idx_ff;

      result.valid          = done;
      result.status         = hbw_pkg::ST_TICK_OK;
      result.expired_id     = '0;
      result.reboot_request = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               action_in = req_action;
               id_in     = req_client_id;
               period_in = req_period;
               issue_in  = '0;
               state_in  = S_SCAN;
               if (req_action) begin
                  time_in = time_ff + hbw_pkg::TIME_W'(1);
               end
            end
         end
         S_SCAN: begin
            rd_valid_in = rd_en;
            rd_idx_in   = issue_ff[IDX_W-1:0];
            if (rd_en) begin
               issue_in = issue_ff + CNT_W'(1);
            end
            if (done) begin
               state_in = S_IDLE;
               if (action_ff) begin
                  if (match) begin
                     count_in              = '0;
                     total_in              = total_inc;
                     result.status         = hbw_pkg::ST_TIMEOUT;
                     result.expired_id     = rd_entry.id;
                     result.reboot_request = (total_inc >= cfg.reboot_limit);
                  end
               end else if (match) begin
                  wr_en         = 1'b1;
                  result.status = hbw_pkg::ST_REFRESHED;
               end else if (count_ff < MAX_COUNT) begin
                  wr_en         = 1'b1;
                  wr_addr       = count_ff[IDX_W-1:0];
                  count_in      = count_ff + CNT_W'(1);
                  result.status = hbw_pkg::ST_REGISTERED;
               end else begin
                  result.status = hbw_pkg::ST_DROPPED;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      count_ext            = {5'b0, count_in};
      result.client_count  = count_ext[hbw_pkg::COUNT_W-1:0];
      result.timeout_total = total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         time_ff     <= '0;
         count_ff    <= '0;
         total_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         time_ff     <= time_in;
         count_ff    <= count_in;
         total_ff    <= total_in;
         rd_valid_ff <= rd_valid_in;
      end
      action_ff <= action_in;
      id_ff     <= id_in;
      period_ff <= period_in;
      issue_ff  <= issue_in;
      rd_idx_ff <= rd_idx_in;
   end

`ifndef SYNTHESIS
   a_rd_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> state_ff == S_SCAN)
      else $error("table read in flight outside a scan");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_COUNT)
      else $error("client count above table depth");

   a_write_on_done: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> done && !action_ff)
      else $error("table write outside heartbeat completion");

   a_timeout_clears: assert property (@(posedge clock) disable iff (reset)
      (result.valid && result.status == hbw_pkg::ST_TIMEOUT) |=> count_ff == '0)
      else $error("table not emptied after timeout");
`endif

endmodule

/* src/multi_client_heartbeat_watchdog_core.sv */
// Top level of the multi-client heartbeat watchdog: CSRs, scan core, result register.
`timescale 1ns / 1ps

// Usage:
//  Request: drive req_action (0 heartbeat, 1 tick), req_client_id and req_period
//  with start high; the beat is taken at a clock edge where busy is low.
//  Config: csr_write_enable, csr_index, csr_data; index 0 is the timeout factor,
//  index 1 the reboot limit. Write only while the block is idle.
//  Response: one beat per request on rsp_* marked by rsp_strobe for one cycle.
//  There is no backpressure; the receiver must take the beat when shown.
//  Timing: each request scans the client table in RAM one entry per cycle.
//  With n entries in use the strobe follows a scan of all n of them; it comes
//  sooner when a heartbeat matches or a tick finds an expired client, as the
//  scan stops at the first hit. The table read pipeline sets the pace.
//  busy drops in the cycle the strobe is shown, so the next request can be
//  accepted at the edge that ends it.
//  Reset (synchronous, active high) empties the table, zeroes time and the
//  timeout total, and restores the CSR defaults (factor 2, limit 3). Table RAM
//  contents are not cleared; only entries below the client count are read.
module multi_client_heartbeat_watchdog_core #(
   parameter int MAX_CLIENTS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_action,
   input  logic [hbw_pkg::ID_W-1:0]       req_client_id,
   input  logic [hbw_pkg::PER_W-1:0]      req_period,
   output logic                           rsp_strobe,
   output logic [hbw_pkg::STATUS_W-1:0]   rsp_status,
   output logic [hbw_pkg::ID_W-1:0]       rsp_expired_id,
   output logic [hbw_pkg::TOTAL_W-1:0]    rsp_timeout_total,
   output logic                           rsp_reboot_request,
   output logic [hbw_pkg::COUNT_W-1:0]    rsp_client_count,
   input  logic                           csr_write_enable,
   input  logic [hbw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hbw_pkg::CSR_DAT_W-1:0]  csr_data
);

   hbw_pkg::cfg_type                  cfg_ff;
   hbw_pkg::result_type               result;
   logic                              accept;
   logic                              strobe_ff;
   logic [hbw_pkg::STATUS_W-1:0]      status_ff;
   logic [hbw_pkg::ID_W-1:0]          expired_ff;
   logic [hbw_pkg::TOTAL_W-1:0]       total_ff;
   logic                              reboot_ff;
   logic [hbw_pkg::COUNT_W-1:0]       count_ff;

   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_factor <= hbw_pkg::FACTOR_RESET;
         cfg_ff.reboot_limit   <= hbw_pkg::LIMIT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            hbw_pkg::CSR_TIMEOUT_FACTOR: begin
               cfg_ff.timeout_factor <= csr_data[hbw_pkg::FACTOR_W-1:0];
            end
            hbw_pkg::CSR_REBOOT_LIMIT: begin
               cfg_ff.reboot_limit <= csr_data[hbw_pkg::LIMIT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   hbw_ctrl #(
      .MAX_CLIENTS (MAX_CLIENTS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .req_action    (req_action),
      .req_client_id (req_client_id),
      .req_period    (req_period),
      .cfg           (cfg_ff),
      .busy          (busy),
      .result        (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= result.valid;
      end
      if (result.valid) begin
         status_ff  <= result.status;
         expired_ff <= result.expired_id;
         total_ff   <= result.timeout_total;
         reboot_ff  <= result.reboot_request;
         count_ff   <= result.client_count;
      end
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_status         = status_ff;
   assign rsp_expired_id     = expired_ff;
   assign rsp_timeout_total  = total_ff;
   assign rsp_reboot_request = reboot_ff;
   assign rsp_client_count   = count_ff;

`ifndef SYNTHESIS
   a_no_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> !busy)
      else $error("response shown while a scan is still running");

   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |=> !strobe_ff)
      else $error("two response beats in a row");

   a_reboot_on_timeout: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && reboot_ff) |-> status_ff == hbw_pkg::ST_TIMEOUT)
      else $error("reboot request without timeout");
`endif

endmodule
